// ===== hdl/tct_pkg.sv =====
// Package for the thermal charge throttle: payload types, threshold
// register map, reset values and current limits.
// No dependencies.
`default_nettype none

package tct_pkg;

	// Up-delay default: qualifying ticks needed before a rise, minus one
	localparam int UP_DELAY_DEF = 2;

	// Charge current limits in mA
	localparam logic [15:0] LIMIT_L1 = 16'd2000;
	localparam logic [15:0] LIMIT_L2 = 16'd400;

	// Throttle levels
	typedef logic [1:0] level_t;
	localparam level_t LVL_0 = 2'd0;
	localparam level_t LVL_1 = 2'd1;
	localparam level_t LVL_2 = 2'd2;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Threshold register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UP_CHARGER_L0   = 3'd0,
		REG_UP_RAIL_L0      = 3'd1,
		REG_UP_CHARGER_L1   = 3'd2,
		REG_UP_RAIL_L1      = 3'd3,
		REG_DOWN_CHARGER_L1 = 3'd4,
		REG_DOWN_RAIL_L1    = 3'd5,
		REG_DOWN_CHARGER_L2 = 3'd6,
		REG_DOWN_RAIL_L2    = 3'd7
	} reg_idx_t;

	// Threshold reset values, degrees C
	localparam logic signed [7:0] RST_UP_CHARGER_L0   = 8'sd53;
	localparam logic signed [7:0] RST_UP_RAIL_L0      = 8'sd46;
	localparam logic signed [7:0] RST_UP_CHARGER_L1   = 8'sd65;
	localparam logic signed [7:0] RST_UP_RAIL_L1      = 8'sd53;
	localparam logic signed [7:0] RST_DOWN_CHARGER_L1 = 8'sd48;
	localparam logic signed [7:0] RST_DOWN_RAIL_L1    = 8'sd46;
	localparam logic signed [7:0] RST_DOWN_CHARGER_L2 = 8'sd54;
	localparam logic signed [7:0] RST_DOWN_RAIL_L2    = 8'sd53;

	// All thresholds, as handed from the register file to the step logic
	typedef struct packed {
		logic signed [7:0] up_charger_l0;
		logic signed [7:0] up_rail_l0;
		logic signed [7:0] up_charger_l1;
		logic signed [7:0] up_rail_l1;
		logic signed [7:0] down_charger_l1;
		logic signed [7:0] down_rail_l1;
		logic signed [7:0] down_charger_l2;
		logic signed [7:0] down_rail_l2;
	} thresholds_t;

	// One tick request
	typedef struct packed {
		logic signed [7:0] chg_temp;
		logic signed [7:0] rail_temp;
		logic              ext_power;
		logic              in_s0;
		logic              typec_sourcing;
		logic [15:0]       req_current;
	} tick_t;

	// One tick result
	typedef struct packed {
		level_t      level;
		logic [15:0] limited_current;
	} limit_t;

endpackage

`default_nettype wire

// ===== hdl/tct_if.sv =====
// Valid/ready channels for the thermal charge throttle: tick requests in,
// limit results out. Depends on tct_pkg.
`default_nettype none

interface tct_in_if
	import tct_pkg::*;
();
	logic  valid;
	logic  ready;
	tick_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tct_out_if
	import tct_pkg::*;
();
	logic   valid;
	logic   ready;
	limit_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/thermal_charge_throttle.sv =====
// Top level of the thermal charge throttle: input register, level/counter
// update logic and result register. Depends on tct_pkg, tct_if, tct_regs.
//
// One request per tick goes in, one result comes out: the throttle level after
// the tick and the requested current clamped to 2000 mA at level 1 or 400 mA
// at level 2. A request is registered, then the level and up-delay counter are
// updated as it moves into the result register, so a request is taken every
// cycle while the sink keeps taking results, each at the earliest at the edge
// after it is loaded. While a result waits, one more request is taken into
// the input register; after that the input stalls until the sink takes the
// result. Thresholds must be written through the cfg port only while no
// request is in flight; the user ensures this, the block does not.
// Loss of external power or S0 clears the level and counter at once.
`default_nettype none

module thermal_charge_throttle
	import tct_pkg::*;
#(
	parameter int UP_DELAY = UP_DELAY_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	tct_in_if.sink                     sample,
	tct_out_if.source                  result
);

	// Counter only needs to hold up to UP_DELAY
	localparam int CntW = (UP_DELAY < 1) ? 1 : $clog2(UP_DELAY + 1);

	thresholds_t     thr;
	logic            valid_s1;
	tick_t           tick_s1;
	logic            valid_s2;
	limit_t          res_s2;
	logic            adv_s1;
	level_t          level_q;
	logic [CntW-1:0] cnt_q;
	level_t          lvl_nxt;
	logic [CntW:0]   cnt_ext;
	logic            hot;
	logic            fall;
	logic [15:0]     lim;

	tct_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr       (thr)
	);

	// Handshake: stage 1 moves on when the result register is free or drains
	assign adv_s1       = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || adv_s1;
	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			tick_s1 <= sample.data;
		end
	end

	// Level and up-delay counter update for the request in stage 1
	always_comb begin
		lvl_nxt = level_q;
		cnt_ext = {1'b0, cnt_q};
		hot     = 1'b0;
		fall    = 1'b0;
		if (tick_s1.ext_power && tick_s1.in_s0) begin
			if (level_q == LVL_0 || level_q == LVL_1) begin
				if (level_q == LVL_0) begin
					hot = (tick_s1.chg_temp >= thr.up_charger_l0)
						&& (tick_s1.rail_temp >= thr.up_rail_l0);
				end else begin
					hot = (tick_s1.chg_temp >= thr.up_charger_l1)
						&& (tick_s1.rail_temp >= thr.up_rail_l1)
						&& tick_s1.typec_sourcing;
				end
				if (hot) begin
					cnt_ext = {1'b0, cnt_q} + (CntW+1)'(1);
					if (cnt_ext > (CntW+1)'(UP_DELAY)) begin
						cnt_ext = '0;
						lvl_nxt = level_q + LVL_1;
					end
				end
			end else begin
				cnt_ext = '0;
			end
			// Fall rule on the level as just updated
			if (lvl_nxt == LVL_1) begin
				fall = (tick_s1.chg_temp < thr.down_charger_l1)
					|| (tick_s1.rail_temp < thr.down_rail_l1);
			end else if (lvl_nxt != LVL_0) begin
				fall = (tick_s1.chg_temp < thr.down_charger_l2)
					|| (tick_s1.rail_temp < thr.down_rail_l2)
					|| !tick_s1.typec_sourcing;
			end
			if (fall) begin
				lvl_nxt = lvl_nxt - LVL_1;
			end
		end else begin
			lvl_nxt = LVL_0;
			cnt_ext = '0;
		end
	end

	// Current clamp by the updated level
	always_comb begin
		lim = tick_s1.req_current;
		if (lvl_nxt == LVL_1) begin
			if (lim > LIMIT_L1) begin
				lim = LIMIT_L1;
			end
		end else if (lvl_nxt != LVL_0) begin
			if (lim > LIMIT_L2) begin
				lim = LIMIT_L2;
			end
		end
	end

	// Throttle state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= LVL_0;
			cnt_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				level_q <= lvl_nxt;
				cnt_q   <= cnt_ext[CntW-1:0];
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2.level           <= lvl_nxt;
			res_s2.limited_current <= lim;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tct_regs.sv =====
// Threshold register file for the thermal charge throttle: eight signed
// 8-bit temperature thresholds, write-only. Depends on tct_pkg.
`default_nettype none

module tct_regs
	import tct_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output thresholds_t                thr
);

	thresholds_t thr_q;

	// Register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.up_charger_l0   <= RST_UP_CHARGER_L0;
			thr_q.up_rail_l0      <= RST_UP_RAIL_L0;
			thr_q.up_charger_l1   <= RST_UP_CHARGER_L1;
			thr_q.up_rail_l1      <= RST_UP_RAIL_L1;
			thr_q.down_charger_l1 <= RST_DOWN_CHARGER_L1;
			thr_q.down_rail_l1    <= RST_DOWN_RAIL_L1;
			thr_q.down_charger_l2 <= RST_DOWN_CHARGER_L2;
			thr_q.down_rail_l2    <= RST_DOWN_RAIL_L2;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_UP_CHARGER_L0:   thr_q.up_charger_l0   <= cfg_data;
				REG_UP_RAIL_L0:      thr_q.up_rail_l0      <= cfg_data;
				REG_UP_CHARGER_L1:   thr_q.up_charger_l1   <= cfg_data;
				REG_UP_RAIL_L1:      thr_q.up_rail_l1      <= cfg_data;
				REG_DOWN_CHARGER_L1: thr_q.down_charger_l1 <= cfg_data;
				REG_DOWN_RAIL_L1:    thr_q.down_rail_l1    <= cfg_data;
				REG_DOWN_CHARGER_L2: thr_q.down_charger_l2 <= cfg_data;
				REG_DOWN_RAIL_L2:    thr_q.down_rail_l2    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign thr = thr_q;

endmodule

`default_nettype wire
